[design/mlfd_pkg.sv]
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types, constants and marker tables for the marker and length
// frame deframer.
// ----------------------------------------------------------------------------
package mlfd_pkg;

  localparam int unsigned HEADER_BYTES  = 24;
  localparam int unsigned LENGTH_OFFSET = 0;
  localparam int unsigned HEAD_LEN      = 16;
  localparam int unsigned TAIL_LEN      = 8;

  localparam logic [7:0] HEAD_MARK [16] = '{
    8'haa, 8'hab, 8'hac, 8'hbb, 8'hba, 8'hbc, 8'hcc, 8'hca,
    8'hcb, 8'hdd, 8'hda, 8'hdb, 8'hee, 8'hea, 8'hff, 8'hfa
  };

  localparam logic [7:0] TAIL_MARK [8] = '{
    8'hae, 8'hbe, 8'hce, 8'hde, 8'h0a, 8'h0b, 8'h0c, 8'h0d
  };

  typedef enum logic [2:0] {
    KIND_HUNT     = 3'd0,
    KIND_HEAD_END = 3'd1,
    KIND_HEADER   = 3'd2,
    KIND_PAYLOAD  = 3'd3,
    KIND_AFTER    = 3'd4,
    KIND_DONE     = 3'd5,
    KIND_LEN_ERR  = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [30:0] plen;
  } result_t;

endpackage

[design/marker_length_frame_deframer.sv]
// ----------------------------------------------------------------------------
// marker_length_frame_deframer
// Tags each received byte with its role in a marker and length delimited
// frame, with an input register and a result register around the core.
// Each accepted byte is held in the input register, then moves with its result into the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the single-step core update.
// Reset: asynchronous active low; the block then hunts for the head marker.
// ----------------------------------------------------------------------------
module marker_length_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [38:8] payload_length, [39] zero
  output logic [2:0]  m_axis_tuser    // [2:0] kind
);
  import mlfd_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  result_t     out_res_q;
  result_t     core_res;
  logic        advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = s_axis_tready ? s_axis_tvalid : in_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  mlfd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .result_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_byte_q <= in_byte_q;
      out_res_q  <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.plen, out_byte_q};
  assign m_axis_tuser  = out_res_q.kind;

endmodule

[design/mlfd_core.sv]
// ----------------------------------------------------------------------------
// mlfd_core
// Frame state and the single-step classification of one received byte:
// head and tail marker matching, header collection and payload counting.
// ----------------------------------------------------------------------------
module mlfd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output mlfd_pkg::result_t result_o
);
  import mlfd_pkg::*;

  typedef enum logic [3:0] {
    PH_HEAD = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_TAIL = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  mm_q, mm_d;
  logic [7:0]  hc_q, hc_d;
  logic [31:0] lw_q, lw_d;
  logic [30:0] pc_q, pc_d;

  logic        tail_sel;
  logic [4:0]  mark_len;
  logic [4:0]  m0;
  logic [4:0]  m1;
  logic [7:0]  mark_b;
  logic [7:0]  first_b;
  logic        hit;
  logic [8:0]  hc_sum;

  always_comb begin
    tail_sel = (phase_q == PH_TAIL);
    mark_len = tail_sel ? 5'(TAIL_LEN) : 5'(HEAD_LEN);
    m0       = (mm_q >= mark_len) ? 5'd0 : mm_q;
    mark_b   = tail_sel ? TAIL_MARK[m0[2:0]] : HEAD_MARK[m0[3:0]];
    first_b  = tail_sel ? TAIL_MARK[0] : HEAD_MARK[0];
    if (byte_i == mark_b) begin
      m1 = m0 + 5'd1;
    end else if (m0 != 5'd0) begin
      m1 = (byte_i == first_b) ? 5'd1 : 5'd0;
    end else begin
      m1 = 5'd0;
    end
    hit = (m1 >= mark_len);
  end

  always_comb begin
    phase_d       = phase_q;
    mm_d          = mm_q;
    hc_d          = hc_q;
    lw_d          = lw_q;
    pc_d          = pc_q;
    hc_sum        = {1'b0, hc_q} + 9'd1;
    result_o.kind = KIND_HUNT;
    result_o.plen = '0;
    case (phase_q)
      PH_HDR: begin
        result_o.kind = KIND_HEADER;
        if (({1'b0, hc_q} >= 9'(LENGTH_OFFSET)) && ({1'b0, hc_q} < 9'(LENGTH_OFFSET + 4))) begin
          lw_d = {lw_q[23:0], byte_i};
        end
        hc_d = hc_sum[7:0];
        if (hc_sum >= 9'(HEADER_BYTES)) begin
          hc_d = '0;
          pc_d = '0;
          mm_d = '0;
          if (lw_d[31]) begin
            result_o.kind = KIND_LEN_ERR;
            phase_d       = PH_HEAD;
          end else if (lw_d == 32'd0) begin
            phase_d = PH_TAIL;
          end else begin
            phase_d = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        result_o.kind = KIND_PAYLOAD;
        result_o.plen = lw_q[30:0];
        pc_d          = pc_q + 31'd1;
        if (pc_d >= lw_q[30:0]) begin
          phase_d = PH_TAIL;
          mm_d    = '0;
        end
      end
      PH_TAIL: begin
        result_o.plen = lw_q[30:0];
        if (hit) begin
          result_o.kind = KIND_DONE;
          phase_d       = PH_HEAD;
          mm_d          = '0;
        end else begin
          result_o.kind = KIND_AFTER;
          mm_d          = m1;
        end
      end
      default: begin
        if (hit) begin
          result_o.kind = KIND_HEAD_END;
          phase_d       = PH_HDR;
          mm_d          = '0;
          hc_d          = '0;
          lw_d          = '0;
          pc_d          = '0;
        end else begin
          result_o.kind = KIND_HUNT;
          phase_d       = PH_HEAD;
          mm_d          = m1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      mm_q    <= '0;
      hc_q    <= '0;
      lw_q    <= '0;
      pc_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      mm_q    <= mm_d;
      hc_q    <= hc_d;
      lw_q    <= lw_d;
      pc_q    <= pc_d;
    end
  end

`ifndef ASSERT_OFF
  a_mm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_q < 5'(HEAD_LEN))
    else $error("marker match count out of range");

  a_tail_mm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TAIL) |-> (mm_q < 5'(TAIL_LEN)))
    else $error("tail match count out of range");

  a_hc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, hc_q} < 9'(HEADER_BYTES))
    else $error("header count out of range");

  a_pay_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (!lw_q[31] && (pc_q < lw_q[30:0])))
    else $error("payload phase with invalid length or count");
`endif

endmodule
